FILE: src/fate_pkg.sv
// ----------------------------------------------------------------------------
// fate_pkg
// Shared constants, opcodes and controller/datapath interface types for the
// flash allocation table engine.
// ----------------------------------------------------------------------------
package fate_pkg;

   // table geometry: four 2-bit entries packed per memory row
   localparam int NUM_FIELDS = 2048;
   localparam int LANES      = 4;
   localparam int ROWS       = NUM_FIELDS / LANES;
   localparam int ROW_W      = $clog2(ROWS);
   localparam int ENT_W      = $clog2(NUM_FIELDS);
   localparam int ST_W       = 2;
   localparam int ROW_DATA_W = LANES * ST_W;

   // field widths
   localparam int OP_W  = 2;
   localparam int IDX_W = 12;
   localparam int CNT_W = 12;

   // operation codes
   localparam logic [OP_W-1:0] OP_ERASE = 2'd0;
   localparam logic [OP_W-1:0] OP_MARK  = 2'd1;
   localparam logic [OP_W-1:0] OP_SCAN  = 2'd2;

   // register indexes
   localparam logic CSR_RESERVED = 1'b0;
   localparam logic CSR_USED     = 1'b1;

   // register reset values and limits
   localparam logic [IDX_W-1:0] FIELDS_MAX   = IDX_W'(NUM_FIELDS);
   localparam logic [IDX_W-1:0] RESERVED_RST = 12'd64;
   localparam logic [IDX_W-1:0] USED_RST     = IDX_W'(NUM_FIELDS);

   // erased row: every entry reads as 3
   localparam logic [ROW_DATA_W-1:0] ERASED_ROW = {ROW_DATA_W{1'b1}};

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic clear;
      logic rd;
      logic mark;
      logic scan;
   } fate_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            err;
      logic            empty;
      logic            trivial;
      logic            mark_last;
      logic            clear_last;
      logic            scan_stop;
   } fate_sts_type;

endpackage

FILE: src/flash_allocation_table_engine.sv
// ----------------------------------------------------------------------------
// flash_allocation_table_engine
// Allocation table of 2-bit field states (valid, invalid, erased) with
// erase, range mark and downward scan commands.
// ----------------------------------------------------------------------------
// Usage:
//   A command word (req_*) is taken on a clock edge with start high and busy
//   low. Exactly one response word follows on rsp_* with rsp_valid high for
//   one cycle; the receiver cannot stall it. A new command may be given in
//   the cycle that carries the response.
//   The table is held in a 512 x 8 memory, four entries per row, and every
//   command works one row per cycle:
//     erase: 512 row writes, then the response
//     mark:  one read-modify-write per touched row, then the response
//     scan:  one row per cycle downward, response once the scan stops
//     errors and trivial cases respond straight from decode, with no sweep
//   Reset loads the register reset values (64 reserved, 2048 in use) and runs
//   an erase sweep over all 512 rows; busy stays high until it ends,
//   and it gives no response.
//   The register port (csr_*) is always ready; the user is to write registers
//   only while no command is in flight, as the block does not enforce it.
// ----------------------------------------------------------------------------
module flash_allocation_table_engine
   import fate_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [OP_W-1:0]   req_operation,
   input  logic [IDX_W-1:0]  req_index,
   input  logic [CNT_W-1:0]  req_count,
   input  logic [ST_W-1:0]   req_entry_state,
   output logic              rsp_valid,
   output logic              rsp_status,
   output logic [IDX_W-1:0]  rsp_found_index,
   output logic [ST_W-1:0]   rsp_found_state,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [IDX_W-1:0]  csr_data
);

   logic [IDX_W-1:0] reserved_ff;
   logic [IDX_W-1:0] used_ff;
   fate_cmd_type     cmd;
   fate_sts_type     sts;

   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         reserved_ff <= RESERVED_RST;
         used_ff     <= USED_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_RESERVED: reserved_ff <= csr_data;
            CSR_USED:     used_ff     <= csr_data;
            default:      ;
         endcase
      end
   end

   fate_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd_o     (cmd),
      .sts_i     (sts)
   );

   fate_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd_i           (cmd),
      .sts_o           (sts),
      .req_operation   (req_operation),
      .req_index       (req_index),
      .req_count       (req_count),
      .req_entry_state (req_entry_state),
      .reserved_fields (reserved_ff),
      .used_fields     (used_ff),
      .rsp_status      (rsp_status),
      .rsp_found_index (rsp_found_index),
      .rsp_found_state (rsp_found_state)
   );

endmodule

FILE: src/fate_ctrl.sv
// ----------------------------------------------------------------------------
// fate_ctrl
// Sequencer for erase, mark and scan: drives row sweeps in the datapath and
// raises the one-cycle response strobe.
// ----------------------------------------------------------------------------
module fate_ctrl
   import fate_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   output logic         rsp_valid,
   output fate_cmd_type cmd_o,
   input  fate_sts_type sts_i
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_DECODE,
      S_MARK,
      S_MARK_END,
      S_SCAN,
      S_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      erase_rsp_ff, erase_rsp_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         erase_rsp_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         erase_rsp_ff <= erase_rsp_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      erase_rsp_in = erase_rsp_ff;
      cmd_o        = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd_o.clear = 1'b1;
            if (sts_i.clear_last) begin
               state_in     = erase_rsp_ff ? S_RESP : S_IDLE;
               erase_rsp_in = 1'b0;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd_o.load = 1'b1;
               state_in   = S_DECODE;
            end
         end
         S_RESP: begin
            if (start) begin
               cmd_o.load = 1'b1;
               state_in   = S_DECODE;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_DECODE: begin
            if (sts_i.op == OP_ERASE) begin
               erase_rsp_in = 1'b1;
               state_in     = S_CLEAR;
            end else if (sts_i.err) begin
               state_in = S_RESP;
            end else if (sts_i.op == OP_MARK) begin
               state_in = sts_i.empty ? S_RESP : S_MARK;
            end else if (sts_i.op == OP_SCAN) begin
               state_in = sts_i.trivial ? S_RESP : S_SCAN;
            end else begin
               state_in = S_RESP;
            end
         end
         S_MARK: begin
            cmd_o.rd   = 1'b1;
            cmd_o.mark = 1'b1;
            if (sts_i.mark_last) begin
               state_in = S_MARK_END;
            end
         end
         S_MARK_END: begin
            // write back the last row read
            cmd_o.mark = 1'b1;
            state_in   = S_RESP;
         end
         S_SCAN: begin
            cmd_o.rd   = 1'b1;
            cmd_o.scan = 1'b1;
            if (sts_i.scan_stop) begin
               state_in = S_RESP;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy      = (state_ff != S_IDLE) && (state_ff != S_RESP);
   assign rsp_valid = (state_ff == S_RESP);

   // a response strobe lasts one cycle
   a_rsp_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP) |=> (state_ff != S_RESP))
      else $error("response strobe held for more than one cycle");

   // an accepted word always goes to decode
   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == S_DECODE))
      else $error("accepted word not decoded");

endmodule

FILE: src/fate_dpath.sv
// ----------------------------------------------------------------------------
// fate_dpath
// Packed state table memory, range checks, mark read-modify-write pipeline
// and the downward scan step over one row per cycle.
// ----------------------------------------------------------------------------
module fate_dpath
   import fate_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  fate_cmd_type      cmd_i,
   output fate_sts_type      sts_o,
   input  logic [OP_W-1:0]   req_operation,
   input  logic [IDX_W-1:0]  req_index,
   input  logic [CNT_W-1:0]  req_count,
   input  logic [ST_W-1:0]   req_entry_state,
   input  logic [IDX_W-1:0]  reserved_fields,
   input  logic [IDX_W-1:0]  used_fields,
   output logic              rsp_status,
   output logic [IDX_W-1:0]  rsp_found_index,
   output logic [ST_W-1:0]   rsp_found_state
);

   logic [ROW_DATA_W-1:0] mem [ROWS];

   logic [OP_W-1:0]       op_ff;
   logic [IDX_W-1:0]      idx_ff;
   logic [IDX_W-1:0]      end_ff;
   logic [ST_W-1:0]       st_ff;
   logic                  err_ff, empty_ff, trivial_ff;
   logic [ROW_W-1:0]      row_ff, row_in;
   logic [ROW_W-1:0]      last_row_ff;
   logic [IDX_W-1:0]      i_ff;
   logic [ST_W-1:0]       fs_ff;
   logic [ROW_DATA_W-1:0] rd_data_ff;
   logic [ROW_W-1:0]      rd_row_ff;
   logic                  rd_vld_ff;

   logic [IDX_W-1:0]      used_eff;
   logic [IDX_W:0]        sum_req;
   logic [IDX_W-1:0]      idx_m1, end_m1;
   logic                  err_in;
   logic [ROW_DATA_W-1:0] wr_data;
   logic [IDX_W-1:0]      i_nx;
   logic [ST_W-1:0]       fs_nx;
   logic                  stop_nx;

   // request checks against the clamped field count
   always_comb begin
      used_eff = (used_fields > FIELDS_MAX) ? FIELDS_MAX : used_fields;
      sum_req  = {1'b0, req_index} + {1'b0, req_count};
      idx_m1   = req_index - 1'b1;
      end_m1   = sum_req[IDX_W-1:0] - 1'b1;
      case (req_operation)
         OP_ERASE: err_in = 1'b0;
         OP_MARK:  err_in = (req_index < reserved_fields) || (sum_req > {1'b0, used_eff});
         OP_SCAN:  err_in = (req_index > used_eff);
         default:  err_in = 1'b1;
      endcase
   end

   // row address for the next sweep
   always_comb begin
      row_in = row_ff;
      if (cmd_i.load) begin
         case (req_operation)
            OP_MARK: row_in = req_index[ENT_W-1:2];
            OP_SCAN: row_in = idx_m1[ENT_W-1:2];
            default: row_in = '0;
         endcase
      end else if (cmd_i.clear || (cmd_i.rd && cmd_i.mark)) begin
         row_in = row_ff + 1'b1;
      end else if (cmd_i.rd && cmd_i.scan) begin
         row_in = row_ff - 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         row_ff    <= row_in;
         rd_vld_ff <= cmd_i.rd;
      end
   end

   // request word capture and scan progress
   always_ff @(posedge clock) begin
      if (cmd_i.load) begin
         op_ff       <= req_operation;
         idx_ff      <= req_index;
         end_ff      <= sum_req[IDX_W-1:0];
         st_ff       <= req_entry_state;
         err_ff      <= err_in;
         empty_ff    <= (req_count == '0);
         trivial_ff  <= (req_index <= reserved_fields);
         last_row_ff <= end_m1[ENT_W-1:2];
         i_ff        <= req_index;
         fs_ff       <= req_entry_state;
      end else if (cmd_i.scan && rd_vld_ff) begin
         i_ff  <= i_nx;
         fs_ff <= fs_nx;
      end
   end

   // mark: and the state into lanes that fall inside the range
   always_comb begin
      logic [IDX_W-1:0] ent;
      wr_data = rd_data_ff;
      for (int l = 0; l < LANES; l++) begin
         ent = IDX_W'({rd_row_ff, 2'(l)});
         if ((ent >= idx_ff) && (ent < end_ff)) begin
            wr_data[l*ST_W +: ST_W] = rd_data_ff[l*ST_W +: ST_W] & st_ff;
         end
      end
   end

   // scan: walk the current row downward from the candidate index
   always_comb begin
      logic [IDX_W-1:0] ent1;
      logic [ST_W-1:0]  val;
      i_nx    = i_ff;
      fs_nx   = fs_ff;
      stop_nx = 1'b0;
      for (int l = LANES - 1; l >= 0; l--) begin
         ent1 = IDX_W'({rd_row_ff, 2'(l)}) + 1'b1;
         val  = rd_data_ff[l*ST_W +: ST_W];
         if (!stop_nx && (i_nx == ent1)) begin
            if ((i_nx > reserved_fields) && (val == st_ff)) begin
               i_nx = i_nx - 1'b1;
            end else begin
               stop_nx = 1'b1;
               fs_nx   = (i_nx > reserved_fields) ? val : st_ff;
            end
         end
      end
      if (!stop_nx && (i_nx <= reserved_fields)) begin
         stop_nx = 1'b1;
         fs_nx   = st_ff;
      end
   end

   // table memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd_i.clear) begin
         mem[row_ff] <= ERASED_ROW;
      end else if (cmd_i.mark && rd_vld_ff) begin
         mem[rd_row_ff] <= wr_data;
      end
      if (cmd_i.rd) begin
         rd_data_ff <= mem[row_ff];
         rd_row_ff  <= row_ff;
      end
   end

   // status to the controller
   always_comb begin
      sts_o.op         = op_ff;
      sts_o.err        = err_ff;
      sts_o.empty      = empty_ff;
      sts_o.trivial    = trivial_ff;
      sts_o.mark_last  = (row_ff == last_row_ff);
      sts_o.clear_last = (row_ff == ROW_W'(ROWS - 1));
      sts_o.scan_stop  = rd_vld_ff && stop_nx;
   end

   // response word
   assign rsp_status      = err_ff;
   assign rsp_found_index = ((op_ff == OP_SCAN) && !err_ff) ? i_ff : '0;
   assign rsp_found_state = ((op_ff == OP_SCAN) && !err_ff) ? fs_ff : '0;

   // clear sweep and mark write-back never share the write port
   a_one_writer: assert property (@(posedge clock) disable iff (reset)
      !(cmd_i.clear && cmd_i.mark && rd_vld_ff))
      else $error("write port conflict");

   // mark reads ahead of the row being written back
   a_rmw_rows: assert property (@(posedge clock) disable iff (reset)
      (cmd_i.mark && cmd_i.rd && rd_vld_ff) |-> (rd_row_ff != row_ff))
      else $error("mark read and write hit the same row");

   // scan candidate index only moves down
   a_scan_down: assert property (@(posedge clock) disable iff (reset)
      (cmd_i.scan && rd_vld_ff) |=> (i_ff <= $past(i_ff)))
      else $error("scan index moved up");

endmodule
